### rtl/multichannel_ima_adpcm_codec_top_defines.svh
// Assertion macros for the IMA ADPCM codec.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef MULTICHANNEL_IMA_ADPCM_CODEC_TOP_DEFINES_SVH
`define MULTICHANNEL_IMA_ADPCM_CODEC_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define IMA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IMA_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IMA_ASSERT(label, clk, rst, prop, msg)
`define IMA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### rtl/ima_pkg.sv
// Shared types, codes and tables of the IMA ADPCM codec.
// No dependencies.
package ima_pkg;
  localparam int DefChannels = 64;
  localparam logic [6:0] MaxIndex = 7'd88;

  localparam logic [1:0] FUNC_ENC  = 2'd0;
  localparam logic [1:0] FUNC_DEC  = 2'd1;
  localparam logic [1:0] FUNC_LOAD = 2'd2;
  localparam logic [1:0] FUNC_READ = 2'd3;

  localparam logic [1:0] KIND_CODE   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_STATE  = 2'd2;

  // Queued work item between front and back.
  typedef struct packed {
    logic [1:0]  func;
    logic [9:0]  channel;
    logic [15:0] data;
    logic        last;
    logic        single;
    logic [15:0] set_pred;
    logic [6:0]  set_index;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  channel;
    logic [15:0] data;
    logic [15:0] pred;
    logic [6:0]  index;
    logic        last;
  } result_t;

  function automatic logic [14:0] step_lookup(input logic [6:0] idx);
    logic [14:0] s;
    case (idx)
      7'd0: s = 15'd7; 7'd1: s = 15'd8; 7'd2: s = 15'd9; 7'd3: s = 15'd10;
      7'd4: s = 15'd11; 7'd5: s = 15'd12; 7'd6: s = 15'd13; 7'd7: s = 15'd14;
      7'd8: s = 15'd16; 7'd9: s = 15'd17; 7'd10: s = 15'd19; 7'd11: s = 15'd21;
      7'd12: s = 15'd23; 7'd13: s = 15'd25; 7'd14: s = 15'd28; 7'd15: s = 15'd31;
      7'd16: s = 15'd34; 7'd17: s = 15'd37; 7'd18: s = 15'd41; 7'd19: s = 15'd45;
      7'd20: s = 15'd50; 7'd21: s = 15'd55; 7'd22: s = 15'd60; 7'd23: s = 15'd66;
      7'd24: s = 15'd73; 7'd25: s = 15'd80; 7'd26: s = 15'd88; 7'd27: s = 15'd97;
      7'd28: s = 15'd107; 7'd29: s = 15'd118; 7'd30: s = 15'd130; 7'd31: s = 15'd143;
      7'd32: s = 15'd157; 7'd33: s = 15'd173; 7'd34: s = 15'd190; 7'd35: s = 15'd209;
      7'd36: s = 15'd230; 7'd37: s = 15'd253; 7'd38: s = 15'd279; 7'd39: s = 15'd307;
      7'd40: s = 15'd337; 7'd41: s = 15'd371; 7'd42: s = 15'd408; 7'd43: s = 15'd449;
      7'd44: s = 15'd494; 7'd45: s = 15'd544; 7'd46: s = 15'd598; 7'd47: s = 15'd658;
      7'd48: s = 15'd724; 7'd49: s = 15'd796; 7'd50: s = 15'd876; 7'd51: s = 15'd963;
      7'd52: s = 15'd1060; 7'd53: s = 15'd1166; 7'd54: s = 15'd1282;
      7'd55: s = 15'd1411; 7'd56: s = 15'd1552; 7'd57: s = 15'd1707;
      7'd58: s = 15'd1878; 7'd59: s = 15'd2066; 7'd60: s = 15'd2272;
      7'd61: s = 15'd2499; 7'd62: s = 15'd2749; 7'd63: s = 15'd3024;
      7'd64: s = 15'd3327; 7'd65: s = 15'd3660; 7'd66: s = 15'd4026;
      7'd67: s = 15'd4428; 7'd68: s = 15'd4871; 7'd69: s = 15'd5358;
      7'd70: s = 15'd5894; 7'd71: s = 15'd6484; 7'd72: s = 15'd7132;
      7'd73: s = 15'd7845; 7'd74: s = 15'd8630; 7'd75: s = 15'd9493;
      7'd76: s = 15'd10442; 7'd77: s = 15'd11487; 7'd78: s = 15'd12635;
      7'd79: s = 15'd13899; 7'd80: s = 15'd15289; 7'd81: s = 15'd16818;
      7'd82: s = 15'd18500; 7'd83: s = 15'd20350; 7'd84: s = 15'd22385;
      7'd85: s = 15'd24623; 7'd86: s = 15'd27086; 7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  function automatic logic [6:0] next_index(input logic [6:0] idx, input logic [2:0] mag);
    logic [7:0] n;
    case (mag)
      3'd4: n = {1'b0, idx} + 8'd2;
      3'd5: n = {1'b0, idx} + 8'd4;
      3'd6: n = {1'b0, idx} + 8'd6;
      3'd7: n = {1'b0, idx} + 8'd8;
      default: n = (idx == 7'd0) ? 8'd0 : {1'b0, idx} - 8'd1;
    endcase
    if (n > {1'b0, MaxIndex}) n = {1'b0, MaxIndex};
    return n[6:0];
  endfunction

  function automatic logic [15:0] clamp16(input logic signed [17:0] v);
    logic [15:0] r;
    if (v > 18'sd32767) r = 16'h7fff;
    else if (v < -18'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction
endpackage

### rtl/ima_front.sv
// Front end: accepts input transactions, drops out-of-range channels,
// and queues work items in a two-entry FIFO. Depends on ima_pkg.
module ima_front #(
  parameter int CHANNELS = ima_pkg::DefChannels
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  ima_pkg::item_t s_item,
  output logic           q_valid,
  input  logic           q_pop,
  output ima_pkg::item_t q_item
);
  import ima_pkg::*;
  `include "multichannel_ima_adpcm_codec_top_defines.svh"

  item_t      fifo [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push;

  assign s_tready = (count != 2'd2);
  // drop items aimed at channels that do not exist
  assign push     = s_tvalid && s_tready && (s_item.channel < CHANNELS);
  assign q_valid  = (count != 2'd0);
  assign q_item   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= s_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  `IMA_ASSERT(a_no_pop_empty, clk, rst, q_pop |-> q_valid, "pop from empty queue")
  `IMA_ASSERT(a_count_range, clk, rst, count != 2'd3, "queue count overflow")
  `IMA_ASSERT(a_pop_count, clk, rst, (q_pop && !push) |=> count == $past(count) - 2'd1,
              "queue count mismatch")
endmodule

### rtl/ima_back.sv
// Back end: channel state memories, encode/decode datapath and output
// register. Each step reads the channel state, then computes and writes it back.
// Depends on ima_pkg.
module ima_back #(
  parameter int CHANNELS = ima_pkg::DefChannels
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_pop,
  input  ima_pkg::item_t   q_item,
  output logic             m_tvalid,
  input  logic             m_tready,
  output ima_pkg::result_t m_res
);
  import ima_pkg::*;
  `include "multichannel_ima_adpcm_codec_top_defines.svh"

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CLR_W = $clog2(CHANNELS + 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [15:0] pred_mem [CHANNELS];
  logic [6:0]  index_mem [CHANNELS];
  logic [4:0]  pend_mem [CHANNELS];

  logic [1:0]  state;
  logic [CLR_W-1:0] clr_cnt;
  logic        second;     // working on the low nibble of a decode
  logic [15:0] pred_rd;
  logic [6:0]  index_rd;
  logic [4:0]  pend_rd;
  logic [CW-1:0] ch;

  assign ch = q_item.channel[CW-1:0];

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      pred_rd  <= pred_mem[ch];
      index_rd <= index_mem[ch];
      pend_rd  <= pend_mem[ch];
    end
  end

  // datapath
  logic [14:0] step;
  logic [3:0]  nib, code;
  logic signed [17:0] diff;
  logic [16:0] ud, ud1, ud2;
  logic [16:0] vp_enc, vp_dec, vp;
  logic [2:0]  emag;
  logic signed [17:0] sum;
  logic [15:0] new_pred;
  logic [6:0]  new_index;
  logic [6:0]  ld_index;
  logic        out_emit;
  result_t     res;

  always_comb begin
    step = step_lookup(index_rd);
    nib  = second ? q_item.data[3:0] : q_item.data[7:4];
    diff = 18'($signed(q_item.data)) - 18'($signed(pred_rd));
    ud   = diff[17] ? 17'(-diff) : diff[16:0];
    emag = 3'd0;
    vp_enc = {5'd0, step[14:3]};
    ud1 = ud;
    if (ud1 >= {2'd0, step}) begin
      emag[2] = 1'b1; ud1 = ud1 - {2'd0, step}; vp_enc = vp_enc + {2'd0, step};
    end
    ud2 = ud1;
    if (ud2 >= {3'd0, step[14:1]}) begin
      emag[1] = 1'b1; ud2 = ud2 - {3'd0, step[14:1]};
      vp_enc = vp_enc + {3'd0, step[14:1]};
    end
    if (ud2 >= {4'd0, step[14:2]}) begin
      emag[0] = 1'b1; vp_enc = vp_enc + {4'd0, step[14:2]};
    end
    vp_dec = {5'd0, step[14:3]} + (nib[2] ? {2'd0, step} : 17'd0)
           + (nib[1] ? {3'd0, step[14:1]} : 17'd0)
           + (nib[0] ? {4'd0, step[14:2]} : 17'd0);
    code = (q_item.func == FUNC_ENC) ? {diff[17], emag} : nib;
    vp   = (q_item.func == FUNC_ENC) ? vp_enc : vp_dec;
    sum  = code[3] ? 18'($signed(pred_rd)) - 18'(vp) : 18'($signed(pred_rd)) + 18'(vp);
    new_pred  = clamp16(sum);
    new_index = next_index(index_rd, code[2:0]);
    ld_index  = (q_item.set_index > MaxIndex) ? MaxIndex : q_item.set_index;

    out_emit = 1'b0;
    res.kind    = KIND_CODE;
    res.channel = q_item.channel[5:0];
    res.data    = 16'd0;
    res.pred    = new_pred;
    res.index   = new_index;
    res.last    = 1'b1;
    case (q_item.func)
      FUNC_ENC: begin
        if (pend_rd[4]) begin
          out_emit = 1'b1; res.data = {8'd0, pend_rd[3:0], code};
        end else if (q_item.last) begin
          out_emit = 1'b1; res.data = {8'd0, code, 4'd0};
        end
      end
      FUNC_DEC: begin
        out_emit = 1'b1;
        res.kind = KIND_SAMPLE;
        res.data = new_pred;
        res.last = second || q_item.single;
      end
      FUNC_LOAD: out_emit = 1'b0;
      default: begin
        out_emit  = 1'b1;
        res.kind  = KIND_STATE;
        res.pred  = pred_rd;
        res.index = index_rd;
      end
    endcase
  end

  logic exec_go, more;
  assign exec_go = (state == ST_EXEC) && (!m_tvalid || m_tready);
  assign more    = (q_item.func == FUNC_DEC) && !second && !q_item.single;
  assign q_pop   = exec_go && !more;

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      pred_mem[clr_cnt[CW-1:0]]  <= 16'd0;
      index_mem[clr_cnt[CW-1:0]] <= 7'd0;
      pend_mem[clr_cnt[CW-1:0]]  <= 5'd0;
    end else if (exec_go) begin
      unique case (q_item.func)
        FUNC_ENC: begin
          pred_mem[ch]  <= new_pred;
          index_mem[ch] <= new_index;
          if (pend_rd[4] || q_item.last) pend_mem[ch] <= 5'd0;
          else pend_mem[ch] <= {1'b1, code};
        end
        FUNC_DEC: begin
          pred_mem[ch]  <= new_pred;
          index_mem[ch] <= new_index;
        end
        FUNC_LOAD: begin
          pred_mem[ch]  <= q_item.set_pred;
          index_mem[ch] <= ld_index;
          pend_mem[ch]  <= 5'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go && out_emit) m_res <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      second   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (exec_go && out_emit) m_tvalid <= 1'b1;
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLR_W'(CHANNELS - 1)) state <= ST_READ;
        end
        ST_READ: if (q_valid) state <= ST_EXEC;
        ST_EXEC: if (exec_go) begin
          state  <= ST_READ;
          second <= more;
        end
        default: state <= ST_READ;
      endcase
    end
  end

  `IMA_ASSERT(a_pop_in_exec, clk, rst, q_pop |-> state == ST_EXEC, "pop outside exec")
  `IMA_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> $stable(m_res),
              "result changed while stalled")
  `IMA_ASSERT(a_second_dec, clk, rst, (second && state == ST_EXEC) |-> q_item.func == FUNC_DEC,
              "second nibble outside decode")
endmodule

### rtl/multichannel_ima_adpcm_codec_top.sv
// Multichannel IMA ADPCM codec, top level.
// Input channel (s_axis): one transaction per command: encode, decode, load or read.
//   s_axis_tdata (lowest bit up): func[1:0], channel[7:2], data_in[23:8],
//   set_pred[39:24], set_index[46:40], zero fill to 48 bits.
//   s_axis_tuser: single_nibble. s_axis_tlast: last_in.
// Output channel (m_axis): code bytes, decoded samples and state reports.
//   m_axis_tdata: channel_out[5:0], data_out[21:6], pred_out[37:22],
//   index_out[44:38], zero fill to 48 bits. m_axis_tuser: kind. m_axis_tlast: last_out.
// Each state step has two states (memory read, then compute and write back),
// and a two-sample decode runs a step per sample. With the back end idle a result
// passes the queue, the read state and the compute state into the output
// register, after any queued steps ahead of it. A two-entry queue separates
// intake from execution, so input is taken while a result waits in the output register.
// After reset the block clears every channel, one per cycle, before it executes;
// items are queued meanwhile. When the receiver stalls, the output register
// holds, then the queue fills and tready drops.
// Depends on ima_pkg, ima_front, ima_back.
module multichannel_ima_adpcm_codec_top #(
  parameter int CHANNELS = ima_pkg::DefChannels
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // func, channel, data_in, set_pred, set_index
  input  logic        s_axis_tuser,   // single_nibble
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // channel_out, data_out, pred_out, index_out
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast
);
  import ima_pkg::*;

  item_t   s_item, q_item;
  result_t res;
  logic    q_valid, q_pop;

  assign s_item.func      = s_axis_tdata[1:0];
  assign s_item.channel   = {4'd0, s_axis_tdata[7:2]};
  assign s_item.data      = s_axis_tdata[23:8];
  assign s_item.set_pred  = s_axis_tdata[39:24];
  assign s_item.set_index = s_axis_tdata[46:40];
  assign s_item.last      = s_axis_tlast;
  assign s_item.single    = s_axis_tuser;

  ima_front #(.CHANNELS(CHANNELS)) u_front (
    .clk, .rst, .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_item,
    .q_valid, .q_pop, .q_item
  );

  ima_back #(.CHANNELS(CHANNELS)) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_item,
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_res(res)
  );

  assign m_axis_tdata = {3'd0, res.index, res.pred, res.data, res.channel};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;
endmodule
